### hdl/bracket_balance_checker_macros.svh
// Assertion macros for the bracket balance checker.
`ifndef BRACKET_BALANCE_CHECKER_MACROS_SVH
`define BRACKET_BALANCE_CHECKER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BBC_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define BBC_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/bbc_pkg.sv
// Shared types and constants of the bracket balance checker.
`timescale 1ns / 1ps

package bbc_pkg;

    // Field widths fixed by the interface
    localparam int CODE_W        = 21;
    localparam int DIAG_OFFSET_W = 24;
    localparam int KIND_W        = 2;

    // Register widths and register file layout
    localparam int MAX_PAIRS     = 3;
    localparam int PAIR_REG_W    = MAX_PAIRS * CODE_W;
    localparam int COMMENT_REG_W = 2 * CODE_W;
    localparam int SMALL_REG_W   = 2;
    localparam int APB_DATA_W    = 64;
    localparam int APB_ADDR_W    = 6;
    localparam int REG_IDX_W     = 3;

    // Default parameter values
    localparam int STACK_DEPTH_DEF = 32;
    localparam int OFFSET_BITS_DEF = 24;
    localparam int PAIR_SLOTS_DEF  = 3;

    // Character codes with fixed meaning
    localparam logic [CODE_W-1:0] CHAR_DQUOTE = 21'h00022;
    localparam logic [CODE_W-1:0] CHAR_SQUOTE = 21'h00027;
    localparam logic [CODE_W-1:0] CHAR_BSLASH = 21'h0005C;
    localparam logic [CODE_W-1:0] CHAR_NL     = 21'h0000A;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_PAIR_OPEN    = 3'd0,
        REG_PAIR_CLOSE   = 3'd1,
        REG_PAIR_COUNT   = 3'd2,
        REG_COMMENT_CHRS = 3'd3,
        REG_COMMENT_LEN  = 3'd4
    } reg_idx_t;

    typedef enum logic [KIND_W-1:0] {
        KIND_UNMATCHED = 2'd0,
        KIND_UNCLOSED  = 2'd1,
        KIND_OVERFLOW  = 2'd2
    } diag_kind_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_REFILL,
        ST_FLUSH
    } bbc_state_t;

    // Decoded configuration handed to the scanner
    typedef struct packed {
        logic [PAIR_REG_W-1:0]  pair_open;
        logic [PAIR_REG_W-1:0]  pair_close;
        logic [SMALL_REG_W-1:0] pairs_active;
        logic [CODE_W-1:0]      comment_first;
        logic [CODE_W-1:0]      comment_second;
        logic [SMALL_REG_W-1:0] comment_len;
    } cfg_t;

endpackage

### hdl/bbc_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module bbc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                                aclk,
    input  logic                                wr_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                    wr_data,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                    rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

### hdl/bbc_cfg.sv
// APB register file of the bracket balance checker.
`timescale 1ns / 1ps

module bbc_cfg #(
    parameter int PAIR_SLOTS = bbc_pkg::PAIR_SLOTS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [bbc_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [bbc_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [bbc_pkg::APB_DATA_W-1:0]  prdata,
    output logic                            pready,
    output bbc_pkg::cfg_t                   cfg
);

    logic [bbc_pkg::PAIR_REG_W-1:0]    pair_open_reg;
    logic [bbc_pkg::PAIR_REG_W-1:0]    pair_close_reg;
    logic [bbc_pkg::SMALL_REG_W-1:0]   pair_count_reg;
    logic [bbc_pkg::COMMENT_REG_W-1:0] comment_chars_reg;
    logic [bbc_pkg::SMALL_REG_W-1:0]   comment_len_reg;
    bbc_pkg::reg_idx_t                 reg_idx;
    logic                              wr_strobe;

    assign pready    = 1'b1;
    assign reg_idx   = bbc_pkg::reg_idx_t'(paddr[bbc_pkg::APB_ADDR_W-1:3]);
    assign wr_strobe = psel && penable && pwrite && pready;

    // Write registers on the access beat; ignore addresses past the list
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pair_open_reg     <= '0;
            pair_close_reg    <= '0;
            pair_count_reg    <= '0;
            comment_chars_reg <= '0;
            comment_len_reg   <= '0;
        end else if (wr_strobe) begin
            unique case (reg_idx)
                bbc_pkg::REG_PAIR_OPEN: begin
                    pair_open_reg <= pwdata[bbc_pkg::PAIR_REG_W-1:0];
                end
                bbc_pkg::REG_PAIR_CLOSE: begin
                    pair_close_reg <= pwdata[bbc_pkg::PAIR_REG_W-1:0];
                end
                bbc_pkg::REG_PAIR_COUNT: begin
                    pair_count_reg <= pwdata[bbc_pkg::SMALL_REG_W-1:0];
                end
                bbc_pkg::REG_COMMENT_CHRS: begin
                    comment_chars_reg <= pwdata[bbc_pkg::COMMENT_REG_W-1:0];
                end
                bbc_pkg::REG_COMMENT_LEN: begin
                    comment_len_reg <= pwdata[bbc_pkg::SMALL_REG_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // Read back raw register values
    always_comb begin
        prdata = '0;
        unique case (reg_idx)
            bbc_pkg::REG_PAIR_OPEN: begin
                prdata = bbc_pkg::APB_DATA_W'(pair_open_reg);
            end
            bbc_pkg::REG_PAIR_CLOSE: begin
                prdata = bbc_pkg::APB_DATA_W'(pair_close_reg);
            end
            bbc_pkg::REG_PAIR_COUNT: begin
                prdata = bbc_pkg::APB_DATA_W'(pair_count_reg);
            end
            bbc_pkg::REG_COMMENT_CHRS: begin
                prdata = bbc_pkg::APB_DATA_W'(comment_chars_reg);
            end
            bbc_pkg::REG_COMMENT_LEN: begin
                prdata = bbc_pkg::APB_DATA_W'(comment_len_reg);
            end
            default: begin
                prdata = '0;
            end
        endcase
    end

    // Clamp pair count to the slots built and marker length to two
    always_comb begin
        cfg.pair_open      = pair_open_reg;
        cfg.pair_close     = pair_close_reg;
        cfg.pairs_active   = (pair_count_reg > bbc_pkg::SMALL_REG_W'(PAIR_SLOTS))
                           ? bbc_pkg::SMALL_REG_W'(PAIR_SLOTS) : pair_count_reg;
        cfg.comment_first  = comment_chars_reg[bbc_pkg::CODE_W-1:0];
        cfg.comment_second = comment_chars_reg[bbc_pkg::COMMENT_REG_W-1:bbc_pkg::CODE_W];
        cfg.comment_len    = (comment_len_reg > 2'd2) ? 2'd2 : comment_len_reg;
    end

endmodule

### hdl/bracket_balance_checker.sv
// Top level of the bracket balance checker: scanner, stack control and result register.
//
//  channel  | handshake          | payload
//  ---------+--------------------+------------------------------------------
//  s_       | s_valid / s_ready  | s_char_code, s_next_code, s_end_of_text
//  m_       | m_valid / m_ready  | m_diag_offset, m_diag_kind, m_last
//  apb      | psel/penable/pready| paddr, pwrite, pwdata, prdata
//
// A close that pops a frame from a stack of two or more passes through a refill state
// while the stack RAM returns the new top frame.
// An end-of-text beat with N open frames enters a flush with one RAM read per frame.
// Synchronous active-low reset clears the scan state; the stack RAM is not cleared.
// s_ready drops while the result register is full and m_ready is low, or during a refill
// or flush.
`timescale 1ns / 1ps

module bracket_balance_checker #(
    parameter int STACK_DEPTH = bbc_pkg::STACK_DEPTH_DEF,
    parameter int OFFSET_BITS = bbc_pkg::OFFSET_BITS_DEF,
    parameter int PAIR_SLOTS  = bbc_pkg::PAIR_SLOTS_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [bbc_pkg::CODE_W-1:0]         s_char_code,
    input  logic [bbc_pkg::CODE_W-1:0]         s_next_code,
    input  logic                               s_end_of_text,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [bbc_pkg::DIAG_OFFSET_W-1:0]  m_diag_offset,
    output logic [bbc_pkg::KIND_W-1:0]         m_diag_kind,
    output logic                               m_last,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [bbc_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [bbc_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [bbc_pkg::APB_DATA_W-1:0]     prdata,
    output logic                               pready
);

    localparam int CW      = $clog2(STACK_DEPTH + 1);
    localparam int AW      = STACK_DEPTH > 1 ? $clog2(STACK_DEPTH) : 1;
    localparam int FRAME_W = bbc_pkg::CODE_W + OFFSET_BITS;
    localparam int OW      = OFFSET_BITS < bbc_pkg::DIAG_OFFSET_W
                           ? OFFSET_BITS : bbc_pkg::DIAG_OFFSET_W;

    bbc_pkg::cfg_t       cfg;
    bbc_pkg::bbc_state_t state_reg, state_next;

    logic [CW-1:0]                 count_reg, count_next;
    logic [OFFSET_BITS-1:0]        off_reg, off_next;
    logic                          in_comment_reg, in_comment_next;
    logic                          in_quote_reg, in_quote_next;
    logic                          quote_dq_reg, quote_dq_next;
    logic                          escape_reg, escape_next;
    logic [bbc_pkg::CODE_W-1:0]    top_close_reg, top_close_next;
    logic [AW-1:0]                 idx_reg, idx_next;
    logic                          m_valid_reg, m_valid_next;
    logic [bbc_pkg::DIAG_OFFSET_W-1:0] out_off_reg, out_off_next;
    bbc_pkg::diag_kind_t           out_kind_reg, out_kind_next;
    logic                          out_last_reg, out_last_next;

    logic                          wr_en;
    logic [AW-1:0]                 wr_addr;
    logic [FRAME_W-1:0]            wr_data;
    logic [AW-1:0]                 rd_addr;
    logic [FRAME_W-1:0]            rd_data;

    logic                          out_free;
    logic                          accept;
    logic                          comment_hit;
    logic                          open_any;
    logic                          close_any;
    logic [bbc_pkg::CODE_W-1:0]    open_close_code;
    logic [bbc_pkg::DIAG_OFFSET_W-1:0] cur_diag_off;
    logic [bbc_pkg::DIAG_OFFSET_W-1:0] frame_diag_off;
    logic                          flush_last;

    bbc_cfg #(
        .PAIR_SLOTS (PAIR_SLOTS)
    ) u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    bbc_ram #(
        .WIDTH (FRAME_W),
        .DEPTH (STACK_DEPTH)
    ) u_stack (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign out_free      = !m_valid_reg || m_ready;
    assign s_ready       = (state_reg == bbc_pkg::ST_IDLE) && out_free;
    assign accept        = s_valid && s_ready;
    assign m_valid       = m_valid_reg;
    assign m_diag_offset = out_off_reg;
    assign m_diag_kind   = out_kind_reg;
    assign m_last        = out_last_reg;
    assign flush_last    = (CW'(idx_reg) == count_reg - CW'(1));

    // Match comment marker against the current and next character
    assign comment_hit = (cfg.comment_len != 2'd0)
                      && (s_char_code == cfg.comment_first)
                      && ((cfg.comment_len == 2'd1) || (s_next_code == cfg.comment_second));

    // Compare against active pairs; lowest open pair wins
    always_comb begin
        open_any        = 1'b0;
        close_any       = 1'b0;
        open_close_code = '0;
        for (int i = PAIR_SLOTS - 1; i >= 0; i--) begin
            if ((2'(i) < cfg.pairs_active)
                && (cfg.pair_open[i*bbc_pkg::CODE_W +: bbc_pkg::CODE_W] == s_char_code)) begin
                open_any        = 1'b1;
                open_close_code = cfg.pair_close[i*bbc_pkg::CODE_W +: bbc_pkg::CODE_W];
            end
            if ((2'(i) < cfg.pairs_active)
                && (cfg.pair_close[i*bbc_pkg::CODE_W +: bbc_pkg::CODE_W] == s_char_code)) begin
                close_any = 1'b1;
            end
        end
    end

    // Fit stored offsets to the result field
    always_comb begin
        cur_diag_off   = '0;
        frame_diag_off = '0;
        cur_diag_off[OW-1:0]   = off_reg[OW-1:0];
        frame_diag_off[OW-1:0] = rd_data[OW-1:0];
    end

    // Next state, stack access and result register loading
    always_comb begin
        state_next      = state_reg;
        count_next      = count_reg;
        off_next        = off_reg;
        in_comment_next = in_comment_reg;
        in_quote_next   = in_quote_reg;
        quote_dq_next   = quote_dq_reg;
        escape_next     = escape_reg;
        top_close_next  = top_close_reg;
        idx_next        = idx_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        out_off_next    = out_off_reg;
        out_kind_next   = out_kind_reg;
        out_last_next   = out_last_reg;
        wr_en           = 1'b0;
        wr_addr         = count_reg[AW-1:0];
        wr_data         = {open_close_code, off_reg};
        rd_addr         = idx_reg;

        unique case (state_reg)
            bbc_pkg::ST_IDLE: begin
                if (accept && s_end_of_text) begin
                    if ((cfg.pairs_active != 2'd0) && (count_reg != '0)) begin
                        // Walk the stack bottom up
                        state_next = bbc_pkg::ST_FLUSH;
                        idx_next   = '0;
                        rd_addr    = '0;
                    end else begin
                        count_next      = '0;
                        off_next        = '0;
                        in_comment_next = 1'b0;
                        in_quote_next   = 1'b0;
                        quote_dq_next   = 1'b0;
                        escape_next     = 1'b0;
                    end
                end else if (accept) begin
                    // Advance the offset, saturating
                    if (off_reg != '1) begin
                        off_next = off_reg + OFFSET_BITS'(1);
                    end
                    priority if (escape_reg) begin
                        escape_next = 1'b0;
                    end else if (in_comment_reg) begin
                        if (s_char_code == bbc_pkg::CHAR_NL) begin
                            in_comment_next = 1'b0;
                        end
                    end else if (!in_quote_reg && comment_hit) begin
                        in_comment_next = 1'b1;
                    end else if (in_quote_reg) begin
                        priority if ((s_char_code == bbc_pkg::CHAR_BSLASH)
                                     && (s_next_code != '0)) begin
                            escape_next = 1'b1;
                        end else if ((quote_dq_reg && (s_char_code == bbc_pkg::CHAR_DQUOTE))
                                  || (!quote_dq_reg && (s_char_code == bbc_pkg::CHAR_SQUOTE)))
                        begin
                            in_quote_next = 1'b0;
                            quote_dq_next = 1'b0;
                        end else begin
                        end
                    end else if ((s_char_code == bbc_pkg::CHAR_DQUOTE)
                              || (s_char_code == bbc_pkg::CHAR_SQUOTE)) begin
                        in_quote_next = 1'b1;
                        quote_dq_next = (s_char_code == bbc_pkg::CHAR_DQUOTE);
                    end else if (open_any) begin
                        if (count_reg == CW'(STACK_DEPTH)) begin
                            // Full stack: report and drop the frame
                            m_valid_next  = 1'b1;
                            out_off_next  = cur_diag_off;
                            out_kind_next = bbc_pkg::KIND_OVERFLOW;
                            out_last_next = 1'b1;
                        end else begin
                            wr_en          = 1'b1;
                            top_close_next = open_close_code;
                            count_next     = count_reg + CW'(1);
                        end
                    end else if (close_any) begin
                        if ((count_reg != '0) && (top_close_reg == s_char_code)) begin
                            count_next = count_reg - CW'(1);
                            if (count_reg > CW'(1)) begin
                                // Fetch the frame below into the top register
                                rd_addr    = AW'(count_reg - CW'(2));
                                state_next = bbc_pkg::ST_REFILL;
                            end
                        end else begin
                            m_valid_next  = 1'b1;
                            out_off_next  = cur_diag_off;
                            out_kind_next = bbc_pkg::KIND_UNMATCHED;
                            out_last_next = 1'b1;
                        end
                    end else begin
                    end
                end
            end
            bbc_pkg::ST_REFILL: begin
                top_close_next = rd_data[OFFSET_BITS +: bbc_pkg::CODE_W];
                state_next     = bbc_pkg::ST_IDLE;
            end
            bbc_pkg::ST_FLUSH: begin
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    out_off_next  = frame_diag_off;
                    out_kind_next = bbc_pkg::KIND_UNCLOSED;
                    out_last_next = flush_last;
                    if (flush_last) begin
                        state_next      = bbc_pkg::ST_IDLE;
                        count_next      = '0;
                        off_next        = '0;
                        in_comment_next = 1'b0;
                        in_quote_next   = 1'b0;
                        quote_dq_next   = 1'b0;
                        escape_next     = 1'b0;
                    end else begin
                        idx_next = idx_reg + AW'(1);
                        rd_addr  = idx_reg + AW'(1);
                    end
                end
            end
            default: begin
                state_next = bbc_pkg::ST_IDLE;
            end
        endcase
    end

    // State register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= bbc_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Scan state and result valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg      <= '0;
            off_reg        <= '0;
            in_comment_reg <= 1'b0;
            in_quote_reg   <= 1'b0;
            quote_dq_reg   <= 1'b0;
            escape_reg     <= 1'b0;
            idx_reg        <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            count_reg      <= count_next;
            off_reg        <= off_next;
            in_comment_reg <= in_comment_next;
            in_quote_reg   <= in_quote_next;
            quote_dq_reg   <= quote_dq_next;
            escape_reg     <= escape_next;
            idx_reg        <= idx_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        top_close_reg <= top_close_next;
        out_off_reg   <= out_off_next;
        out_kind_reg  <= out_kind_next;
        out_last_reg  <= out_last_next;
    end

endmodule

### hdl/bbc_checker.sv
// Port-level assertions of the bracket balance checker and their bind.
`timescale 1ns / 1ps
`include "bracket_balance_checker_macros.svh"

module bbc_checker (
    input logic                               aclk,
    input logic                               aresetn,
    input logic                               s_ready,
    input logic                               m_valid,
    input logic                               m_ready,
    input logic [bbc_pkg::DIAG_OFFSET_W-1:0]  m_diag_offset,
    input logic [bbc_pkg::KIND_W-1:0]         m_diag_kind,
    input logic                               m_last
);

    // Hold a stalled result beat
    `BBC_ASSERT_NXT(a_hold_stalled, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_diag_offset) && $stable(m_diag_kind) && $stable(m_last), "stalled result beat changed")

    // Only the flush gives beats that are not last
    `BBC_ASSERT_IMP(a_nonlast_unclosed, aclk, aresetn, m_valid && !m_last, m_diag_kind == bbc_pkg::KIND_UNCLOSED, "non-last beat is not an unclosed report")

    // Flush beats follow without gaps
    `BBC_ASSERT_NXT(a_flush_streams, aclk, aresetn, m_valid && m_ready && !m_last, m_valid && (m_diag_kind == bbc_pkg::KIND_UNCLOSED), "gap inside a flush")

    // Hold off input until the flush is done
    `BBC_ASSERT_IMP(a_no_input_in_flush, aclk, aresetn, m_valid && !m_last, !s_ready, "input taken during a flush")

endmodule

bind bracket_balance_checker bbc_checker u_bbc_checker (.*);
